/* hw/rtl/dpp_pkg.sv */
package dpp_pkg;

  // Parser defaults and packet layout
  localparam int unsigned PACKET_LENGTH_DEF = 17;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  localparam logic [7:0] SYNC_BYTE   = 8'h01;
  localparam logic [7:0] ID_SENSOR   = 8'hD7;
  localparam logic [7:0] ID_STOP     = 8'hE0;
  localparam logic [7:0] ID_OVERRIDE = 8'hDF;

  localparam int unsigned POS_START = 0;
  localparam int unsigned POS_ID    = 1;
  localparam int unsigned POS_ACK   = 6;
  localparam int unsigned POS_DRIVE = 8;
  localparam int unsigned POS_STEER = 9;

  localparam logic [15:0] SAFETY_PERIOD_RESET = 16'd350;
  localparam logic [15:0] ELAPSED_MAX         = 16'hFFFF;

  // Register map (word index)
  localparam logic REG_SAFETY_PERIOD = 1'b0;

  // Speed mixing: ceil(47d/125) = floor((47d+124)*16778 >> 21), exact for d < 256
  localparam logic [27:0] DRIVE_MUL   = 28'd788566;   // 47 * 16778
  localparam logic [27:0] DRIVE_ADD   = 28'd2080472;  // 124 * 16778
  localparam logic [14:0] STEER_MUL   = 15'd117;
  localparam logic [14:0] STEER_BIAS  = 15'd15000;
  // floor(a/1000) = (a*16778) >> 24, exact for a <= 15000
  localparam logic [14:0] RECIP_1000  = 15'd16778;
  localparam logic [7:0]  MOTOR1_BASE = 8'd112;
  localparam logic [7:0]  MOTOR2_BASE = 8'd240;
  localparam logic [7:0]  MOTOR_STOP  = 8'd0;

  typedef enum logic [1:0] {
    KIND_STOP     = 2'd0,
    KIND_SENSOR   = 2'd1,
    KIND_OVERRIDE = 2'd2
  } kind_e;

  // One unit of work for the back end: a stop byte or a sensor mix
  typedef struct packed {
    logic       sensor;
    logic [7:0] drive;
    logic [7:0] steer;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
    job_t job;
  } queue_status_t;

endpackage

/* hw/rtl/dpp_in_if.sv */
interface dpp_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink (input valid, input op, input rx_byte, output ready);
endinterface

/* hw/rtl/dpp_out_if.sv */
interface dpp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] motor_byte;
  logic       last_of_run;

  modport source (output valid, output motor_byte, output last_of_run, input ready);
  modport sink (input valid, input motor_byte, input last_of_run, output ready);
endinterface

/* hw/rtl/drive_packet_parser_with_safety_stop_core.sv */
// Channel   Dir  Payload                    Moves
// in_req    in   op, rx_byte                one link byte or one millisecond tick
// out_res   out  motor_byte, last_of_run    one motor command byte
// apb       in   paddr, pwdata / prdata     safety_period_ms at byte address 0
//
// A request is taken every cycle while the job queue has room; the parser and
// the safety timer update in the cycle of acceptance. A request that yields
// output places one job in the queue; the back end passes it through two
// multiply stages, then the output register, and drives one result per cycle
// while the output is ready: one byte for a stop, two for a sensor packet, so
// sustained rate is set by the output register. Reset clears the parser,
// timer, queue and pipeline; the period returns to 350. A stalled output holds
// the back end, and the front keeps taking requests until the queue is full.
module drive_packet_parser_with_safety_stop_core import dpp_pkg::*; #(
  parameter int unsigned PACKET_LENGTH = PACKET_LENGTH_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpp_in_if.sink      in_req,
  dpp_out_if.source   out_res,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [15:0]   period_q;
  push_t         push;
  queue_status_t queue_st;
  logic          pop;
  logic          cfg_write;

  // Configuration: one register, written in the APB access phase
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_SAFETY_PERIOD);
  assign prdata_o  = (paddr_i[2] == REG_SAFETY_PERIOD) ? {16'd0, period_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= SAFETY_PERIOD_RESET;
    end else if (cfg_write) begin
      period_q <= pwdata_i[15:0];
    end
  end

  // Front: parse bytes, run the safety timer, classify into jobs
  dpp_front #(
    .PACKET_LENGTH (PACKET_LENGTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req   (in_req),
    .period_i (period_q),
    .queue_i  (queue_st),
    .push_o   (push)
  );

  // Queue: decouple the parser from a stalled output
  dpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .status_o (queue_st)
  );

  // Back: mix speeds and emit motor bytes
  dpp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .queue_i (queue_st),
    .pop_o   (pop),
    .out_res (out_res)
  );

endmodule

/* hw/rtl/dpp_front.sv */
module dpp_front import dpp_pkg::*; #(
  parameter int unsigned PACKET_LENGTH = PACKET_LENGTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dpp_in_if.sink        in_req,
  input  logic [15:0]   period_i,
  input  queue_status_t queue_i,
  output push_t         push_o
);

  localparam int unsigned POS_W = $clog2(PACKET_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(PACKET_LENGTH - 1);
  localparam logic [POS_W-1:0] P_START   = POS_W'(POS_START);
  localparam logic [POS_W-1:0] P_ID      = POS_W'(POS_ID);
  localparam logic [POS_W-1:0] P_ACK     = POS_W'(POS_ACK);
  localparam logic [POS_W-1:0] P_DRIVE   = POS_W'(POS_DRIVE);
  localparam logic [POS_W-1:0] P_STEER   = POS_W'(POS_STEER);

  logic [POS_W-1:0] pos_q, pos_d;
  kind_e            kind_q, kind_d;
  logic             ack_q, ack_d;
  logic [7:0]       drive_q, drive_d;
  logic [7:0]       steer_q, steer_d;
  logic [15:0]      elapsed_q, elapsed_d;
  logic             stopped_q, stopped_d;
  logic             accept;
  logic [7:0]       b;

  assign in_req.ready = !queue_i.full;
  assign accept       = in_req.valid && in_req.ready;
  assign b            = in_req.rx_byte;

  always_comb begin
    pos_d     = pos_q;
    kind_d    = kind_q;
    ack_d     = ack_q;
    drive_d   = drive_q;
    steer_d   = steer_q;
    elapsed_d = elapsed_q;
    stopped_d = stopped_q;
    push_o.valid      = 1'b0;
    push_o.job.sensor = 1'b0;
    push_o.job.drive  = drive_q;
    push_o.job.steer  = steer_q;

    if (accept) begin
      if (in_req.op) begin
        // millisecond tick: run the safety check once the period is reached
        if (elapsed_q >= period_i) begin
          elapsed_d = '0;
          if (ack_q) begin
            stopped_d = 1'b0;
          end else if (!stopped_q) begin
            push_o.valid = 1'b1;
            stopped_d    = 1'b1;
          end
          ack_d = 1'b0;
        end else if (elapsed_q != ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end else if (pos_q >= LAST_POS) begin
        // end of packet, byte value is irrelevant
        pos_d = P_START;
        case (kind_q)
          KIND_STOP: begin
            push_o.valid = 1'b1;
          end
          KIND_SENSOR: begin
            push_o.valid      = 1'b1;
            push_o.job.sensor = 1'b1;
          end
          default: begin
          end
        endcase
      end else begin
        unique case (pos_q)
          P_START: begin
            if (b == SYNC_BYTE) pos_d = P_ID;
          end
          P_ID: begin
            pos_d = pos_q + POS_W'(1);
            if (b == ID_SENSOR) begin
              kind_d = KIND_SENSOR;
            end else if (b == ID_STOP) begin
              kind_d = KIND_STOP;
            end else if (b == ID_OVERRIDE) begin
              kind_d = KIND_OVERRIDE;
            end else begin
              pos_d = P_START;
            end
          end
          P_ACK: begin
            if (b <= 8'd1) begin
              ack_d = b[0];
              pos_d = pos_q + POS_W'(1);
            end else begin
              pos_d = P_START;
            end
          end
          default: begin
            if (pos_q == P_DRIVE) drive_d = b;
            else if (pos_q == P_STEER) steer_d = b;
            pos_d = pos_q + POS_W'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      kind_q    <= KIND_STOP;
      ack_q     <= 1'b0;
      drive_q   <= '0;
      steer_q   <= '0;
      elapsed_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      kind_q    <= kind_d;
      ack_q     <= ack_d;
      drive_q   <= drive_d;
      steer_q   <= steer_d;
      elapsed_q <= elapsed_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

/* hw/rtl/dpp_queue.sv */
module dpp_queue import dpp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  push_t         push_i,
  input  logic          pop_i,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.job   = mem_q[rd_q];

  assign do_push = push_i.valid && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LAST_SLOT) ? '0 : wr_q + PTR_W'(1);
    if (do_pop)  rd_d = (rd_q == LAST_SLOT) ? '0 : rd_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_i.job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/dpp_back.sv */
module dpp_back import dpp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t queue_i,
  output logic          pop_o,
  dpp_out_if.source     out_res
);

  // stage 1: drive product, steer magnitude
  logic        s1_valid_q;
  logic        s1_sensor_q;
  logic [27:0] s1_prod_q;
  logic [13:0] s1_mag_q;
  logic        s1_neg_q;
  // stage 2: drop and steer offset magnitude
  logic        s2_valid_q;
  logic        s2_sensor_q;
  logic [6:0]  s2_drop_q;
  logic [3:0]  s2_off_q;
  logic        s2_neg_q;
  // output register with one held second byte
  logic [1:0]  cnt_q;
  logic [7:0]  motor_q;
  logic [7:0]  second_q;

  logic        r_free, adv2, s2_free, adv1, s1_free;
  logic [27:0] prod_d;
  logic [14:0] steer_w;
  logic        neg_d;
  logic [13:0] mag_d;
  logic [28:0] recip_prod;
  logic [7:0]  off8, m1, m2;

  assign r_free  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_res.ready);
  assign adv2    = s2_valid_q && r_free;
  assign s2_free = !s2_valid_q || adv2;
  assign adv1    = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || adv1;
  assign pop_o   = queue_i.valid && s1_free;

  assign out_res.valid       = (cnt_q != 2'd0);
  assign out_res.motor_byte  = motor_q;
  assign out_res.last_of_run = (cnt_q == 2'd1);

  always_comb begin
    prod_d  = {20'd0, queue_i.job.drive} * DRIVE_MUL + DRIVE_ADD;
    steer_w = {7'd0, queue_i.job.steer} * STEER_MUL;
    neg_d   = (steer_w < STEER_BIAS);
    mag_d   = neg_d ? 14'(STEER_BIAS - steer_w) : 14'(steer_w - STEER_BIAS);
  end

  assign recip_prod = {15'd0, s1_mag_q} * {14'd0, RECIP_1000};

  always_comb begin
    off8 = s2_neg_q ? (8'd0 - {4'd0, s2_off_q}) : {4'd0, s2_off_q};
    m1   = MOTOR1_BASE - {1'b0, s2_drop_q} + off8;
    m2   = MOTOR2_BASE - {1'b0, s2_drop_q} - off8;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_sensor_q <= queue_i.job.sensor;
      s1_prod_q   <= prod_d;
      s1_mag_q    <= mag_d;
      s1_neg_q    <= neg_d;
    end
    if (adv1) begin
      s2_sensor_q <= s1_sensor_q;
      s2_drop_q   <= s1_prod_q[27:21];
      s2_off_q    <= recip_prod[27:24];
      s2_neg_q    <= s1_neg_q;
    end
    if (adv2) begin
      motor_q  <= s2_sensor_q ? m1 : MOTOR_STOP;
      second_q <= m2;
    end else if (cnt_q == 2'd2 && out_res.ready) begin
      motor_q <= second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (pop_o) s1_valid_q <= 1'b1;
      else if (adv1) s1_valid_q <= 1'b0;
      if (adv1) s2_valid_q <= 1'b1;
      else if (adv2) s2_valid_q <= 1'b0;
      if (adv2) cnt_q <= s2_sensor_q ? 2'd2 : 2'd1;
      else if (out_res.valid && out_res.ready) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* test/dpp_checker.sv */
module dpp_checker import dpp_pkg::*; #(
  parameter int unsigned PACKET_LENGTH = PACKET_LENGTH_DEF,
  parameter logic        TICK_OP       = 1'b1,
  parameter logic [2:0]  PERIOD_ADDR   = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dpp_in_if           in_mon,
  dpp_out_if          out_mon,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic [31:0] prdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          motor_bytes_o,
  output int          safety_stops_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] motor_byte;
    logic       last_of_run;
  } motor_cmd_t;

  motor_cmd_t  expected_cmd_q[$];
  motor_cmd_t  oldest_cmd;

  logic [15:0] period_ms;
  logic [4:0]  parse_pos;
  kind_e       cmd_kind;
  logic        ack_seen;
  logic [7:0]  drive_sample;
  logic [7:0]  steer_sample;
  logic [15:0] elapsed_ms;
  logic        motors_stopped;

  int n_fail;
  int n_motor;
  int n_stops;

  // ceil(47d/125) drop from drive, trunc((117s-15000)/1000) steer offset
  task automatic predict_sensor_mix();
    int drop;
    int offset;
    drop   = (47 * int'(drive_sample) + 124) / 125;
    offset = (int'(STEER_MUL) * int'(steer_sample) - int'(STEER_BIAS)) / 1000;
    expected_cmd_q.push_back('{8'(int'(MOTOR1_BASE) - drop + offset), 1'b0});
    expected_cmd_q.push_back('{8'(int'(MOTOR2_BASE) - drop - offset), 1'b1});
  endtask

  task automatic predict_tick();
    if (elapsed_ms >= period_ms) begin
      elapsed_ms = '0;
      if (ack_seen) begin
        motors_stopped = 1'b0;
      end else if (!motors_stopped) begin
        expected_cmd_q.push_back('{MOTOR_STOP, 1'b1});
        motors_stopped = 1'b1;
        n_stops++;
      end
      ack_seen = 1'b0;
    end else if (elapsed_ms < ELAPSED_MAX) begin
      elapsed_ms = elapsed_ms + 16'd1;
    end
  endtask

  task automatic predict_byte(input logic [7:0] rx);
    if (parse_pos >= PACKET_LENGTH - 1) begin
      // end byte closes the packet whatever its value
      parse_pos = '0;
      case (cmd_kind)
        KIND_STOP:   expected_cmd_q.push_back('{MOTOR_STOP, 1'b1});
        KIND_SENSOR: predict_sensor_mix();
        default: ;
      endcase
    end else if (parse_pos == POS_START) begin
      if (rx == SYNC_BYTE) parse_pos = 5'd1;
    end else if (parse_pos == POS_ID) begin
      parse_pos = parse_pos + 5'd1;
      case (rx)
        ID_SENSOR:   cmd_kind = KIND_SENSOR;
        ID_STOP:     cmd_kind = KIND_STOP;
        ID_OVERRIDE: cmd_kind = KIND_OVERRIDE;
        default:     parse_pos = '0;
      endcase
    end else if (parse_pos == POS_ACK) begin
      if (rx <= 8'd1) begin
        ack_seen  = rx[0];
        parse_pos = parse_pos + 5'd1;
      end else begin
        parse_pos = '0;
      end
    end else begin
      if (parse_pos == POS_DRIVE) drive_sample = rx;
      else if (parse_pos == POS_STEER) steer_sample = rx;
      parse_pos = parse_pos + 5'd1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ms      = SAFETY_PERIOD_RESET;
      parse_pos      = '0;
      cmd_kind       = KIND_STOP;
      ack_seen       = 1'b0;
      drive_sample   = '0;
      steer_sample   = '0;
      elapsed_ms     = '0;
      motors_stopped = 1'b0;
      expected_cmd_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == PERIOD_ADDR) begin
        if (pwrite_i) begin
          period_ms = pwdata_i[15:0];
        end else if (prdata_i[15:0] !== period_ms) begin
          n_fail++;
          $error("prdata: expected %0d, got %0d", period_ms, prdata_i[15:0]);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == TICK_OP) predict_tick();
        else predict_byte(in_mon.rx_byte);
      end

      if (out_mon.valid === 1'b1 && out_mon.ready) begin
        n_motor++;
        if (expected_cmd_q.size() == 0) begin
          n_fail++;
          $error("motor_byte: expected nothing, got %0d", out_mon.motor_byte);
        end else begin
          oldest_cmd = expected_cmd_q.pop_front();
          if (out_mon.motor_byte !== oldest_cmd.motor_byte) begin
            n_fail++;
            $error("motor_byte: expected %0d, got %0d",
                   oldest_cmd.motor_byte, out_mon.motor_byte);
          end
          if (out_mon.last_of_run !== oldest_cmd.last_of_run) begin
            n_fail++;
            $error("last_of_run: expected %0d, got %0d",
                   oldest_cmd.last_of_run, out_mon.last_of_run);
          end
        end
      end
    end
    // publish after the edge so readers at this edge see the old values
    fail_count_o   <= n_fail;
    pending_o      <= expected_cmd_q.size();
    motor_bytes_o  <= n_motor;
    safety_stops_o <= n_stops;
  end

endmodule

/* test/testbench.sv */
module testbench import dpp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Request codes on the op field
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0]  PERIOD_ADDR     = 3'(REG_SAFETY_PERIOD) << 2;
  localparam int unsigned ITEMS_PER_PHASE = 370;
  localparam int unsigned LONG_HOLD       = 400;
  // pipeline is three stages plus a four-deep queue; leave generous slack
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned LONG_PERIOD_TICKS = 40;

  typedef enum {
    PKT_WELL_FORMED,
    PKT_BAD_ID,
    PKT_BAD_ACK,
    PKT_TRUNCATED
  } pkt_shape_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dpp_in_if  in_ch ();
  dpp_out_if out_ch ();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        long_hold_req;
  logic        long_hold_done;

  int fail_count;
  int pending;
  int motor_bytes;
  int safety_stops;

  int unsigned reqs_sent;
  int unsigned packets_sent;
  int unsigned quiet_cycles;

  drive_packet_parser_with_safety_stop_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  dpp_checker #(
    .PACKET_LENGTH (PACKET_LENGTH_DEF),
    .TICK_OP       (OP_TICK),
    .PERIOD_ADDR   (PERIOD_ADDR)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .motor_bytes_o  (motor_bytes),
    .safety_stops_o (safety_stops)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall at the phase's rate, or hold off once for a long stretch
  // on request so the job queue fills and the block pushes back on its input.
  initial begin
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either channel too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("drive_packet_parser_with_safety_stop_core: mismatch");
    $finish;
  end

  // Offer one request and hold it until the block takes it. Insert idle
  // cycles first at the sender's rate; valid stays high into the next call.
  task automatic send_req(input logic op, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= rx;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Two-phase APB access; return only after psel has been driven low, so
  // back-to-back accesses never drive psel twice in one step.
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, let every expected motor byte drain and the back end go
  // quiet, then write the period and read it back. Sample the pending count
  // only after the clock has advanced, so it includes the last accepted request.
  task automatic set_period(input logic [15:0] period_val);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_access(1'b1, PERIOD_ADDR, {16'h0000, period_val});
    apb_access(1'b0, PERIOD_ADDR, '0);
  endtask

  // Favor the byte extremes so drive and steer hit both ends of the mix.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // Send one packet, well formed or broken, with ticks sprinkled in between.
  task automatic send_packet(input pkt_shape_e shape, input int unsigned tick_pct);
    logic [7:0]  pkt [PACKET_LENGTH_DEF];
    logic [7:0]  bad_id;
    int unsigned n_bytes;
    foreach (pkt[i]) pkt[i] = pick_byte();
    pkt[POS_START] = SYNC_BYTE;
    case ($urandom_range(3))
      0, 1:    pkt[POS_ID] = ID_SENSOR;
      2:       pkt[POS_ID] = ID_STOP;
      default: pkt[POS_ID] = ID_OVERRIDE;
    endcase
    pkt[POS_ACK] = 8'($urandom_range(1));
    n_bytes = PACKET_LENGTH_DEF;
    case (shape)
      PKT_BAD_ID: begin
        do bad_id = 8'($urandom());
        while (bad_id == ID_SENSOR || bad_id == ID_STOP || bad_id == ID_OVERRIDE);
        pkt[POS_ID] = bad_id;
        n_bytes = POS_ID + 1;
      end
      PKT_BAD_ACK: begin
        pkt[POS_ACK] = 8'($urandom_range(255, 2));
        n_bytes = POS_ACK + 1;
      end
      PKT_TRUNCATED: n_bytes = $urandom_range(PACKET_LENGTH_DEF - 1, 2);
      default: ;
    endcase
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < tick_pct) begin
        send_req(OP_TICK, 8'($urandom()));
        reqs_sent++;
      end
      send_req(OP_BYTE, pkt[i]);
      reqs_sent++;
    end
    packets_sent++;
  endtask

  // One random phase: mostly well-formed packets, some broken ones and a
  // little line noise, under the given idling and safety period.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input logic [15:0] period_val, input int unsigned tick_pct,
                           input logic hold_off);
    int unsigned first_req;
    int unsigned pick;
    set_period(period_val);
    send_idle_pct   = idle_pct;
    recv_stall_pct <= stall_pct;
    if (hold_off) long_hold_req <= 1'b1;
    first_req = reqs_sent;
    while (reqs_sent - first_req < ITEMS_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 75)      send_packet(PKT_WELL_FORMED, tick_pct);
      else if (pick < 80) send_packet(PKT_BAD_ID, tick_pct);
      else if (pick < 85) send_packet(PKT_BAD_ACK, tick_pct);
      else if (pick < 92) send_packet(PKT_TRUNCATED, tick_pct);
      else repeat ($urandom_range(4, 1)) send_req(OP_BYTE, pick_byte());
    end
  endtask

  initial begin
    // drive every input known from time zero, hold reset low, then release it
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_BYTE;
    in_ch.rx_byte  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    long_hold_req  <= 1'b0;
    recv_stall_pct <= 0;
    send_idle_pct  = 0;
    reqs_sent      = 0;
    packets_sent   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset period.
    // Drop bytes that are not a start byte.
    send_req(OP_BYTE, 8'hFF);
    send_req(OP_BYTE, 8'h00);
    // A start byte in the id slot is a bad id, not a fresh start.
    send_req(OP_BYTE, SYNC_BYTE);
    send_req(OP_BYTE, SYNC_BYTE);
    // Abort on an ack byte other than 0 or 1.
    send_req(OP_BYTE, SYNC_BYTE);
    send_req(OP_BYTE, ID_STOP);
    repeat (4) send_req(OP_BYTE, 8'hFF);
    send_req(OP_BYTE, 8'h02);
    // A full stop packet with ack set: one stop byte, motors not marked.
    send_req(OP_BYTE, SYNC_BYTE);
    send_req(OP_BYTE, ID_STOP);
    for (int i = 2; i < PACKET_LENGTH_DEF; i++) begin
      send_req(OP_BYTE, (i == POS_ACK) ? 8'h01 : 8'hFF);
    end

    // Shortest period: the first check clears on the ack, the next one stops
    // the motors, later ones stay quiet while they are stopped.
    set_period(16'd1);
    repeat (6) send_req(OP_TICK, 8'($urandom()));

    // Random phases; fill the queue during the first with a long hold-off.
    run_phase(0,  0,  16'd1,  25, 1'b1);
    run_phase(74, 0,  16'd17, 30, 1'b0);
    run_phase(0,  74, 16'd0,  10, 1'b0);
    run_phase(26, 26, 16'($urandom_range(40, 2)), 30, 1'b0);

    // Longest period: a run of ticks stays far below it, so no check fires.
    set_period(16'hFFFF);
    send_idle_pct   = 0;
    recv_stall_pct <= 0;
    repeat (LONG_PERIOD_TICKS) send_req(OP_TICK, 8'($urandom()));
    send_packet(PKT_WELL_FORMED, 0);

    // Let the last results drain, then give the back end time to settle.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d packets in %0d counted requests across six period settings",
             packets_sent, reqs_sent);
    $display("checked %0d motor bytes, %0d of them safety stops", motor_bytes, safety_stops);
    if (fail_count == 0 && pending == 0) begin
      $display("drive_packet_parser_with_safety_stop_core: match");
    end else begin
      $display("drive_packet_parser_with_safety_stop_core: mismatch");
    end
    $finish;
  end

endmodule
